@@ design/sadc_pkg.sv @@
// Shared constants and types for the serial converter read sequencer.
package sadc_pkg;

  localparam int DATA_BITS_DEF   = 8;
  localparam int PHASE_W         = 6;
  localparam int TICK_W          = 8;
  localparam int SAMPLE_W        = 8;

  localparam logic [TICK_W-1:0] HALF_PERIOD_RST = 8'd1;

  // half period boundaries of the command frame
  localparam logic [PHASE_W-1:0] H_START_END  = 6'd3;
  localparam logic [PHASE_W-1:0] H_ODD_END    = 6'd5;
  localparam logic [PHASE_W-1:0] H_SEL_END    = 6'd7;
  localparam logic [PHASE_W-1:0] H_SETTLE     = 6'd8;
  localparam logic [PHASE_W-1:0] H_FIRST_SAMP = 6'd10;

  // pin levels for one tick
  typedef struct packed {
    logic cs_n;
    logic sclk;
    logic dio_out;
    logic dio_drive;
    logic busy;
    logic done;
  } pins_t;

endpackage

@@ design/sadc_step.sv @@
// Next-state and pin logic for one tick of the read sequence.
module sadc_step #(
  parameter int DATA_BITS = sadc_pkg::DATA_BITS_DEF
) (
  input  logic [sadc_pkg::PHASE_W-1:0]  phase_i,
  input  logic [sadc_pkg::TICK_W-1:0]   tick_i,
  input  logic [DATA_BITS-1:0]          msb_i,
  input  logic [DATA_BITS-1:0]          lsb_i,
  input  logic [1:0]                    chan_i,
  input  logic [sadc_pkg::TICK_W-1:0]   half_period,
  input  logic                          start_req,
  input  logic [1:0]                    channel,
  input  logic                          dio_in,
  output logic [sadc_pkg::PHASE_W-1:0]  phase_nxt,
  output logic [sadc_pkg::TICK_W-1:0]   tick_nxt,
  output logic [DATA_BITS-1:0]          msb_nxt,
  output logic [DATA_BITS-1:0]          lsb_nxt,
  output logic [1:0]                    chan_nxt,
  output sadc_pkg::pins_t               pins,
  output logic                          words_match,
  output logic [sadc_pkg::SAMPLE_W-1:0] word_top
);

  localparam int PW       = sadc_pkg::PHASE_W;
  localparam int TW       = sadc_pkg::TICK_W;
  localparam int NUM_HALVES = 9 + 4 * DATA_BITS;
  localparam int IDX_W    = $clog2(DATA_BITS);

  localparam logic [PW-1:0] LAST_HALF = PW'(NUM_HALVES - 1);
  localparam logic [PW-1:0] MSB_LAST  = PW'(DATA_BITS - 1);
  localparam logic [PW-1:0] BITS_PW   = PW'(DATA_BITS);

  logic          start;
  logic [PW-1:0] ph_eff;
  logic [TW-1:0] tick_eff;
  logic [DATA_BITS-1:0] msb_eff;
  logic [DATA_BITS-1:0] lsb_eff;
  logic [1:0]    chan_eff;
  logic [PW-1:0] h;
  logic [PW-1:0] s;
  logic [PW-1:0] lsb_pos;
  logic [TW-1:0] hp;
  logic          half_end;
  logic          sample_slot;
  logic          level;

  assign start    = (phase_i == '0) && start_req;
  assign ph_eff   = start ? PW'(1) : phase_i;
  assign tick_eff = start ? '0 : tick_i;
  assign msb_eff  = start ? '0 : msb_i;
  assign lsb_eff  = start ? '0 : lsb_i;
  assign chan_eff = start ? channel : chan_i;
  assign h        = ph_eff - PW'(1);
  assign s        = (h - sadc_pkg::H_FIRST_SAMP) >> 1;
  assign lsb_pos  = s - MSB_LAST;
  assign hp       = (half_period == '0) ? TW'(1) : half_period;
  assign half_end = ({1'b0, tick_eff} + (TW+1)'(1)) >= {1'b0, hp};
  assign sample_slot = half_end && (h >= sadc_pkg::H_FIRST_SAMP) && !h[0];

  always_comb begin
    if (h <= sadc_pkg::H_START_END) begin
      level = 1'b1;
    end else if (h <= sadc_pkg::H_ODD_END) begin
      level = chan_eff[0];
    end else if (h <= sadc_pkg::H_SEL_END) begin
      level = chan_eff[1];
    end else if (h == sadc_pkg::H_SETTLE) begin
      level = 1'b1;
    end else begin
      level = 1'b0;
    end
  end

  always_comb begin
    msb_nxt   = msb_eff;
    lsb_nxt   = lsb_eff;
    tick_nxt  = tick_eff;
    phase_nxt = ph_eff;
    chan_nxt  = chan_eff;
    pins      = '{cs_n: 1'b1, sclk: 1'b0, dio_out: 1'b0, dio_drive: 1'b0,
                  busy: 1'b0, done: 1'b0};
    if (ph_eff != '0) begin
      pins.cs_n      = 1'b0;
      pins.busy      = 1'b1;
      pins.sclk      = h[0];
      pins.dio_drive = (h <= sadc_pkg::H_SETTLE);
      pins.dio_out   = level;
      if (half_end) begin
        tick_nxt = '0;
        if (sample_slot) begin
          if (s < BITS_PW) begin
            msb_nxt = {msb_eff[DATA_BITS-2:0], dio_in};
            // last MSB-first bit is also bit 0 of the LSB-first word
            if (s == MSB_LAST) begin
              lsb_nxt[0] = lsb_eff[0] | dio_in;
            end
          end else if (lsb_pos < BITS_PW) begin
            lsb_nxt[lsb_pos[IDX_W-1:0]] = lsb_eff[lsb_pos[IDX_W-1:0]] | dio_in;
          end
        end
        if (h >= LAST_HALF) begin
          pins.done = 1'b1;
          phase_nxt = '0;
        end else begin
          phase_nxt = ph_eff + PW'(1);
        end
      end else begin
        tick_nxt = tick_eff + TW'(1);
      end
    end
  end

  assign words_match = (msb_nxt == lsb_nxt);
  assign word_top    = msb_nxt[DATA_BITS-1 -: sadc_pkg::SAMPLE_W];

endmodule

@@ design/serial_adc_read_sequencer_core.sv @@
// Top level of the serial converter read sequencer: request registers, state, result register.
// Each request is one tick of the pin sequence; one enters every cycle unless a held result
// waits on out_ready, and passes the input register, then the result register, with one
// request in flight per stage. A conversion spans (9 + 4*DATA_BITS) serial clock half
// periods of cfg_wr_data ticks each (0 acts as 1); the chip select, clock and data pin
// levels of each tick come back in its result, and sample/mismatch update on the tick
// with out_done_res high. A start request while a conversion runs is ignored.
module serial_adc_read_sequencer_core #(
  parameter int DATA_BITS = sadc_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sadc_pkg::TICK_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_start_req,
  input  logic [1:0]                    in_channel,
  input  logic                          in_dio_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_cs_n,
  output logic                          out_sclk,
  output logic                          out_dio_out,
  output logic                          out_dio_drive,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic [sadc_pkg::SAMPLE_W-1:0] out_sample,
  output logic                          out_mismatch
);

  localparam int PW = sadc_pkg::PHASE_W;
  localparam int TW = sadc_pkg::TICK_W;
  localparam int SW = sadc_pkg::SAMPLE_W;

  logic [TW-1:0]        half_period_r;
  logic                 in_valid_r;
  logic                 start_r;
  logic [1:0]           channel_r;
  logic                 dio_r;
  logic [PW-1:0]        phase_r, phase_nxt;
  logic [TW-1:0]        tick_r, tick_nxt;
  logic [DATA_BITS-1:0] msb_r, msb_nxt;
  logic [DATA_BITS-1:0] lsb_r, lsb_nxt;
  logic [1:0]           chan_r, chan_nxt;
  logic [SW-1:0]        last_sample_r;
  logic                 last_mismatch_r;
  logic                 out_valid_r;
  sadc_pkg::pins_t      pins, pins_r;
  logic                 words_match;
  logic [SW-1:0]        word_top;
  logic                 proc;
  logic [SW-1:0]        sample_nxt;
  logic                 mismatch_nxt;

  assign proc     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proc;

  sadc_step #(
    .DATA_BITS(DATA_BITS)
  ) u_step (
    .phase_i    (phase_r),
    .tick_i     (tick_r),
    .msb_i      (msb_r),
    .lsb_i      (lsb_r),
    .chan_i     (chan_r),
    .half_period(half_period_r),
    .start_req  (start_r),
    .channel    (channel_r),
    .dio_in     (dio_r),
    .phase_nxt  (phase_nxt),
    .tick_nxt   (tick_nxt),
    .msb_nxt    (msb_nxt),
    .lsb_nxt    (lsb_nxt),
    .chan_nxt   (chan_nxt),
    .pins       (pins),
    .words_match(words_match),
    .word_top   (word_top)
  );

  always_comb begin
    sample_nxt   = last_sample_r;
    mismatch_nxt = last_mismatch_r;
    if (pins.done) begin
      sample_nxt   = words_match ? word_top : '0;
      mismatch_nxt = !words_match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= sadc_pkg::HALF_PERIOD_RST;
    end else if (cfg_wr_en) begin
      half_period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      start_r   <= in_start_req;
      channel_r <= in_channel;
      dio_r     <= in_dio_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= '0;
      tick_r          <= '0;
      msb_r           <= '0;
      lsb_r           <= '0;
      chan_r          <= '0;
      last_sample_r   <= '0;
      last_mismatch_r <= 1'b0;
    end else if (proc) begin
      phase_r         <= phase_nxt;
      tick_r          <= tick_nxt;
      msb_r           <= msb_nxt;
      lsb_r           <= lsb_nxt;
      chan_r          <= chan_nxt;
      last_sample_r   <= sample_nxt;
      last_mismatch_r <= mismatch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload; last_* regs carry the same sample/mismatch values
  always_ff @(posedge clk) begin
    if (proc) begin
      pins_r <= pins;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cs_n      = pins_r.cs_n;
  assign out_sclk      = pins_r.sclk;
  assign out_dio_out   = pins_r.dio_out;
  assign out_dio_drive = pins_r.dio_drive;
  assign out_busy_res  = pins_r.busy;
  assign out_done_res  = pins_r.done;
  assign out_sample    = last_sample_r;
  assign out_mismatch  = last_mismatch_r;

endmodule
